>>> design/rcwc_pkg.sv
`default_nettype none

package rcwc_pkg;

    localparam int SEQ_W   = 64;
    localparam int WIN_W   = 11;
    localparam int RTT_W   = 16;
    localparam int RTO_W   = 20;
    localparam int DUP_W   = 3;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Event kinds carried in the input tuser.
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RTT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RTT_DEV = 2'd3;

    localparam logic [WIN_W-1:0] INIT_THRESH_RST  = 11'd64;
    localparam logic [DUP_W-1:0] DUP_LIMIT_RST    = 3'd3;
    localparam logic [RTT_W-1:0] INIT_RTT_RST     = 16'd20;
    localparam logic [RTT_W-1:0] INIT_RTT_DEV_RST = 16'd5;
    localparam logic [RTO_W-1:0] RTO_RST          = 20'd40;

    localparam logic [RTO_W-1:0] RTO_MAX    = 20'hFFFFF;
    localparam logic [DUP_W-1:0] DUP_MAX    = 3'd7;
    localparam logic [WIN_W:0]   FR_INFLATE = 12'd3;

    typedef enum logic [1:0] {
        PH_SLOW_START = 2'd0,
        PH_AVOIDANCE  = 2'd1,
        PH_RECOVERY   = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase                 phase;
        logic [WIN_W-1:0]       cwnd;
        logic [WIN_W-1:0]       ssthresh;
        logic [SEQ_W-1:0]       base;
        logic                   retransmit;
        logic [RTO_W-1:0]       rto;
    } t_snap;

endpackage

`default_nettype wire

>>> design/reno_congestion_window_control_core.sv
`default_nettype none

// TCP Reno sender congestion control. Each input word is one event (restart,
// retransmission timeout or ACK with an RTT sample, selected by tuser) and
// yields one output word with the phase, window, threshold, send base, send
// limit, retransmit flag and retransmission timeout after that event. The
// block sustains one word per clock when the output is not stalled: the whole
// state update is done in the single cycle in which a word leaves the input
// register, and the send limit multiply-add is done in the following output
// stage; each result then passes the snapshot and output registers.
// Configuration writes are applied at once; threshold and RTT values take
// effect on the next restart event, the duplicate limit on the next duplicate ACK.
module reno_congestion_window_control_core
    import rcwc_pkg::*;
#(
    parameter int SEGMENT_BYTES = 1400,
    parameter int MAX_WINDOW    = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // ack_number [63:0], sample_rtt_ms [79:64]
    input  wire logic [79:0]           i_s_tdata,
    // action [1:0]
    input  wire logic [ACT_W-1:0]      i_s_tuser,

    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // phase [1:0], window_segments [12:2], threshold_segments [23:13],
    // base_sequence [87:24], window_limit [151:88], retransmit [152],
    // timeout_ms [172:153], zero fill [175:173]
    output logic [175:0]               o_m_tdata
);

    localparam int WIN_CAP = (MAX_WINDOW < 2047) ? MAX_WINDOW : 2047;
    // Byte distance at and above which the segment count only matters as
    // "at least a full window".
    localparam longint CLAMP_BYTES = longint'(WIN_CAP) * longint'(SEGMENT_BYTES);
    localparam int DIFF_W = $clog2(CLAMP_BYTES);
    localparam int SEG_LOG = $clog2(SEGMENT_BYTES);
    localparam int RECIP_SH = DIFF_W + SEG_LOG;
    localparam longint RECIP =
        ((longint'(1) << RECIP_SH) + longint'(SEGMENT_BYTES) - 1) / longint'(SEGMENT_BYTES);
    localparam int PROD_A = 2 * DIFF_W + 1;
    localparam int PROD_B = RECIP_SH + WIN_W;
    localparam int PROD_W = (PROD_A > PROD_B) ? PROD_A : PROD_B;
    localparam int SEGB_W = $clog2(SEGMENT_BYTES + 1);
    localparam logic [WIN_W-1:0] THRESH_RST_CAP =
        (int'(INIT_THRESH_RST) > WIN_CAP) ? WIN_W'(WIN_CAP) : INIT_THRESH_RST;

    function automatic logic [WIN_W-1:0] f_cap(input logic [WIN_W:0] v);
        logic [WIN_W-1:0] res;
        if (v >= (WIN_W+1)'(WIN_CAP)) begin
            res = WIN_W'(WIN_CAP);
        end else begin
            res = v[WIN_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [WIN_W-1:0] r_cfg_thresh;
    logic [DUP_W-1:0] r_cfg_dup_limit;
    logic [RTT_W-1:0] r_cfg_rtt;
    logic [RTT_W-1:0] r_cfg_rtt_dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thresh    <= INIT_THRESH_RST;
            r_cfg_dup_limit <= DUP_LIMIT_RST;
            r_cfg_rtt       <= INIT_RTT_RST;
            r_cfg_rtt_dev   <= INIT_RTT_DEV_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INIT_THRESH:  r_cfg_thresh    <= i_cfg_wdata[WIN_W-1:0];
                CFG_DUP_LIMIT:    r_cfg_dup_limit <= i_cfg_wdata[DUP_W-1:0];
                CFG_INIT_RTT:     r_cfg_rtt       <= i_cfg_wdata;
                CFG_INIT_RTT_DEV: r_cfg_rtt_dev   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline handshake.
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic w_s1_ready, w_s2_ready, w_s3_ready;
    logic w_s1_fire, w_s2_fire;

    assign w_s3_ready = !r_s3_valid || i_m_tready;
    assign w_s2_ready = !r_s2_valid || w_s3_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_s1_fire  = r_s1_valid && w_s2_ready;
    assign w_s2_fire  = r_s2_valid && w_s3_ready;
    assign o_s_tready = w_s1_ready;

    // Input register.
    logic [ACT_W-1:0] r_s1_action;
    logic [SEQ_W-1:0] r_s1_ack;
    logic [RTT_W-1:0] r_s1_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_s_tvalid) begin
            r_s1_action <= i_s_tuser;
            r_s1_ack    <= i_s_tdata[SEQ_W-1:0];
            r_s1_sample <= i_s_tdata[SEQ_W +: RTT_W];
        end
    end

    // Congestion state.
    t_phase           r_phase,    n_phase;
    logic [WIN_W-1:0] r_cwnd,     n_cwnd;
    logic [WIN_W-1:0] r_ssthresh, n_ssthresh;
    logic [DUP_W-1:0] r_dup,      n_dup;
    // Stays below the largest window, so it never reaches its 11-bit limit.
    logic [WIN_W-1:0] r_avoid,    n_avoid;
    logic [SEQ_W-1:0] r_base,     n_base;
    logic [RTT_W-1:0] r_rtt_est,  n_rtt_est;
    logic [RTT_W-1:0] r_rtt_dev,  n_rtt_dev;
    logic [RTO_W-1:0] r_rto,      n_rto;
    logic             n_retransmit;

    // New-ACK segment count, clamped to the window cap.
    logic [SEQ_W-1:0]  w_diff;
    logic              w_ack_new;
    logic              w_diff_big;
    logic [PROD_W-1:0] w_prod;
    logic [WIN_W-1:0]  w_segs;

    assign w_ack_new  = r_s1_ack > r_base;
    assign w_diff     = r_s1_ack - r_base;
    assign w_diff_big = w_diff >= SEQ_W'(CLAMP_BYTES);
    assign w_prod     = PROD_W'(w_diff[DIFF_W-1:0]) * PROD_W'(RECIP);
    assign w_segs     = w_diff_big ? WIN_W'(WIN_CAP) : w_prod[RECIP_SH +: WIN_W];

    // RTT estimator.
    logic [19:0]      w_est_sum;
    logic [RTT_W-1:0] w_est_new;
    logic [RTT_W-1:0] w_abs_err;
    logic [17:0]      w_dev_sum;
    logic [RTT_W-1:0] w_dev_new;
    logic [RTO_W-1:0] w_rto_new;
    logic [RTO_W:0]   w_rto_dbl;
    logic [RTO_W-1:0] w_rto_restart;

    assign w_est_sum = ({1'b0, r_rtt_est, 3'b000} - 20'(r_rtt_est)) + 20'(r_s1_sample);
    assign w_est_new = w_est_sum[18:3];
    assign w_abs_err = (r_s1_sample >= w_est_new) ? (r_s1_sample - w_est_new)
                                                  : (w_est_new - r_s1_sample);
    assign w_dev_sum = {1'b0, r_rtt_dev, 1'b0} + 18'(r_rtt_dev) + 18'(w_abs_err);
    assign w_dev_new = w_dev_sum[17:2];
    assign w_rto_new = RTO_W'(w_est_new) + {2'b00, w_dev_new, 2'b00};
    assign w_rto_dbl = {r_rto, 1'b0};
    assign w_rto_restart = RTO_W'(r_cfg_rtt) + {2'b00, r_cfg_rtt_dev, 2'b00};

    // Duplicate-ACK bookkeeping in slow start or avoidance.
    logic [DUP_W-1:0] w_dup_inc;
    logic             w_fast_rexmit;
    logic [WIN_W:0]   w_avoid_sum;

    assign w_dup_inc     = (r_dup == DUP_MAX) ? DUP_MAX : r_dup + 1'b1;
    assign w_fast_rexmit = (r_cfg_dup_limit != '0) && (w_dup_inc == r_cfg_dup_limit);
    assign w_avoid_sum   = {1'b0, r_avoid} + {1'b0, w_segs};

    always_comb begin
        n_phase      = r_phase;
        n_cwnd       = r_cwnd;
        n_ssthresh   = r_ssthresh;
        n_dup        = r_dup;
        n_avoid      = r_avoid;
        n_base       = r_base;
        n_rtt_est    = r_rtt_est;
        n_rtt_dev    = r_rtt_dev;
        n_rto        = r_rto;
        n_retransmit = 1'b0;
        unique case (r_s1_action)
            ACT_RESTART: begin
                n_phase    = PH_SLOW_START;
                n_cwnd     = WIN_W'(1);
                n_ssthresh = f_cap({1'b0, r_cfg_thresh});
                n_dup      = '0;
                n_avoid    = '0;
                n_base     = r_s1_ack;
                n_rtt_est  = r_cfg_rtt;
                n_rtt_dev  = r_cfg_rtt_dev;
                n_rto      = w_rto_restart;
            end
            ACT_TIMEOUT: begin
                n_phase      = PH_SLOW_START;
                n_ssthresh   = {1'b0, r_cwnd[WIN_W-1:1]};
                n_cwnd       = WIN_W'(1);
                n_dup        = '0;
                n_retransmit = 1'b1;
                n_rto        = w_rto_dbl[RTO_W] ? RTO_MAX : w_rto_dbl[RTO_W-1:0];
            end
            ACT_ACK: begin
                n_rtt_est = w_est_new;
                n_rtt_dev = w_dev_new;
                n_rto     = w_rto_new;
                if (w_ack_new) begin
                    n_base = r_s1_ack;
                    n_dup  = '0;
                    unique case (r_phase)
                        PH_SLOW_START: begin
                            n_avoid = '0;
                            n_cwnd  = f_cap({1'b0, r_cwnd} + {1'b0, w_segs});
                        end
                        PH_AVOIDANCE: begin
                            if (w_avoid_sum >= {1'b0, r_cwnd}) begin
                                n_cwnd  = f_cap({1'b0, r_cwnd} + 1'b1);
                                n_avoid = '0;
                            end else begin
                                n_avoid = w_avoid_sum[WIN_W-1:0];
                            end
                        end
                        default: begin
                            n_avoid = '0;
                            n_cwnd  = (r_ssthresh > WIN_W'(1)) ? r_ssthresh : WIN_W'(1);
                            n_phase = PH_AVOIDANCE;
                        end
                    endcase
                end else begin
                    unique case (r_phase)
                        PH_SLOW_START, PH_AVOIDANCE: begin
                            if (r_phase == PH_SLOW_START) begin
                                n_avoid = '0;
                            end
                            n_dup = w_dup_inc;
                            if (w_fast_rexmit) begin
                                n_ssthresh   = {1'b0, r_cwnd[WIN_W-1:1]};
                                n_cwnd       = f_cap({2'b00, r_cwnd[WIN_W-1:1]} + FR_INFLATE);
                                n_phase      = PH_RECOVERY;
                                n_retransmit = 1'b1;
                            end
                        end
                        default: begin
                            n_avoid = '0;
                            n_cwnd  = f_cap({1'b0, r_cwnd} + 1'b1);
                        end
                    endcase
                end
                if (n_phase == PH_SLOW_START && n_cwnd >= n_ssthresh) begin
                    n_phase = PH_AVOIDANCE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SLOW_START;
            r_cwnd     <= WIN_W'(1);
            r_ssthresh <= THRESH_RST_CAP;
            r_dup      <= '0;
            r_avoid    <= '0;
            r_base     <= '0;
            r_rtt_est  <= INIT_RTT_RST;
            r_rtt_dev  <= INIT_RTT_DEV_RST;
            r_rto      <= RTO_RST;
        end else if (w_s1_fire) begin
            r_phase    <= n_phase;
            r_cwnd     <= n_cwnd;
            r_ssthresh <= n_ssthresh;
            r_dup      <= n_dup;
            r_avoid    <= n_avoid;
            r_base     <= n_base;
            r_rtt_est  <= n_rtt_est;
            r_rtt_dev  <= n_rtt_dev;
            r_rto      <= n_rto;
        end
    end

    // Result snapshot of the state after the event.
    t_snap r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_s2.phase      <= n_phase;
            r_s2.cwnd       <= n_cwnd;
            r_s2.ssthresh   <= n_ssthresh;
            r_s2.base       <= n_base;
            r_s2.retransmit <= n_retransmit;
            r_s2.rto        <= n_rto;
        end
    end

    // Output stage: send limit is base plus the window in bytes, wrapping.
    logic [WIN_W+SEGB_W-1:0] w_win_bytes;
    logic [SEQ_W-1:0]        w_limit;
    logic [175:0]            r_s3_data;

    assign w_win_bytes = (WIN_W+SEGB_W)'(r_s2.cwnd) * (WIN_W+SEGB_W)'(SEGMENT_BYTES);
    assign w_limit     = r_s2.base + SEQ_W'(w_win_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire) begin
            r_s3_data <= {3'b000, r_s2.rto, r_s2.retransmit, w_limit, r_s2.base,
                          r_s2.ssthresh, r_s2.cwnd, r_s2.phase};
        end
    end

    assign o_m_tvalid = r_s3_valid;
    assign o_m_tdata  = r_s3_data;

endmodule

`default_nettype wire
